// ===== hw/rtl/pngenc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 step for the PNG stream encoder.
// No dependencies; every other file imports this package.
package pngenc_pkg;

  localparam int DIM_W         = 13;
  localparam int MAX_DIMENSION = 4096;
  localparam int RAW_W         = 27;
  localparam int CMDQ_DEPTH    = 2;

  // Stored-deflate block size; pngenc_back's block count relies on 2^16 - 1.
  localparam logic [15:0] STORED_BLOCK_BYTES = 16'hFFFF;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic {CMD_START, CMD_PIXEL} cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic             first_col;
    logic             last_pix;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [31:0]      argb;
  } cmd_t;

  typedef enum logic [1:0] {ST_IDLE, ST_HEAD, ST_RAW, ST_TAIL} back_state_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/pngenc_front.sv =====
// Front end: accepts items, keeps row/column position and image size, and
// turns starts and in-frame pixels into commands. Depends on pngenc_pkg.
module pngenc_front import pngenc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [31:0]      pixel_argb,
  output logic             push,
  output cmd_t             push_cmd,
  input  logic             q_ready
);

  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;
  logic [11:0]      column_count;
  logic [11:0]      row_count;
  logic             frame_active;
  logic [DIM_W-1:0] cfg_clamped;
  logic             accept;
  logic             last_col;
  logic             last_row;

  assign in_ready = q_ready;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (action == ACT_START || frame_active);

  assign last_col = ({1'b0, column_count} + 13'd1) >= width;
  assign last_row = ({1'b0, row_count} + 13'd1) >= height;

  always_comb begin
    cfg_clamped = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_W'(MAX_DIMENSION)) begin
      cfg_clamped = DIM_W'(MAX_DIMENSION);
    end
  end

  always_comb begin
    push_cmd.kind      = (action == ACT_START) ? CMD_START : CMD_PIXEL;
    push_cmd.first_col = (column_count == '0);
    push_cmd.last_pix  = last_col && last_row;
    push_cmd.width     = width;
    push_cmd.height    = height;
    push_cmd.argb      = pixel_argb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width        <= DIM_W'(1);
      height       <= DIM_W'(1);
      column_count <= '0;
      row_count    <= '0;
      frame_active <= 1'b0;
    end else begin
      if (cfg_write_en && !frame_active) begin
        case (cfg_index)
          REG_WIDTH:  width  <= cfg_clamped;
          REG_HEIGHT: height <= cfg_clamped;
          default:    ;
        endcase
      end
      if (push) begin
        if (action == ACT_START) begin
          column_count <= '0;
          row_count    <= '0;
          frame_active <= 1'b1;
        end else if (last_col) begin
          column_count <= '0;
          if (last_row) begin
            row_count    <= '0;
            frame_active <= 1'b0;
          end else begin
            row_count <= row_count + 12'd1;
          end
        end else begin
          column_count <= column_count + 12'd1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/pngenc_cmdq.sv =====
// Short command queue between front and back ends.
// Depends on pngenc_pkg for the command word type.
module pngenc_cmdq import pngenc_pkg::*; #(
  parameter int DEPTH = CMDQ_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic wr_ready,
  output logic rd_valid,
  output cmd_t rd_cmd,
  input  logic rd_en
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/pngenc_back.sv =====
// Back end: byte sequencer for headers, stored blocks, pixels and trailer,
// with running CRC-32 and Adler-32 and a registered output word. Depends on pngenc_pkg.
module pngenc_back import pngenc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       file_done
);

  back_state_t      state;
  back_state_t      state_next;
  cmd_t             cur;
  logic [5:0]       idx;
  logic [2:0]       hidx;
  logic [2:0]       raw_idx;
  logic [31:0]      hcrc;
  logic [31:0]      idat_crc;
  logic [15:0]      adler_low;
  logic [15:0]      adler_high;
  logic [15:0]      block_left;
  logic [RAW_W-1:0] raw_left;
  logic [10:0]      blocks;
  logic [31:0]      idat_len;

  logic             adv;
  logic             fire;
  logic             done;
  logic             to_tail;
  logic             is_raw;
  logic             feed_h;
  logic             feed_i;
  logic             fin;
  logic [7:0]       byte_sel;
  logic [7:0]       raw_byte;
  logic [15:0]      blk_len;
  logic [15:0]      blk_nlen;
  logic [14:0]      w4p1;
  logic [27:0]      raw_full;
  logic [27:0]      blk_t;
  logic [27:0]      blk_q;
  logic [16:0]      low_sum;
  logic [16:0]      low_mod;
  logic [16:0]      high_sum;
  logic [16:0]      high_mod;

  assign adv    = !out_valid || out_ready;
  assign fire   = adv && (state != ST_IDLE);
  assign q_take = q_valid && ((state == ST_IDLE) || (fire && done));

  assign w4p1     = {q_cmd.width, 2'b00} + 15'd1;
  assign raw_full = w4p1 * q_cmd.height;

  // Block count: ceil(raw / 65535) by the 2^16 - 1 reciprocal identity.
  assign blk_t = {1'b0, raw_left} + 28'd65534;
  assign blk_q = (blk_t + (blk_t >> 16) + 28'd1) >> 16;

  assign blk_len  = (raw_left > RAW_W'(STORED_BLOCK_BYTES)) ? STORED_BLOCK_BYTES
                                                            : raw_left[15:0];
  assign blk_nlen = ~blk_len;

  always_comb begin
    case (raw_idx)
      3'd1:    raw_byte = cur.argb[23:16];
      3'd2:    raw_byte = cur.argb[15:8];
      3'd3:    raw_byte = cur.argb[7:0];
      3'd4:    raw_byte = cur.argb[31:24];
      default: raw_byte = 8'h00;
    endcase
  end

  assign low_sum  = {1'b0, adler_low} + {9'd0, raw_byte};
  assign low_mod  = (low_sum >= ADLER_MOD) ? low_sum - ADLER_MOD : low_sum;
  assign high_sum = {1'b0, adler_high} + low_mod;
  assign high_mod = (high_sum >= ADLER_MOD) ? high_sum - ADLER_MOD : high_sum;

  // Output side: byte selection, CRC feeds and end-of-command flags
  always_comb begin
    byte_sel = 8'h00;
    feed_h   = 1'b0;
    feed_i   = 1'b0;
    done     = 1'b0;
    to_tail  = 1'b0;
    is_raw   = 1'b0;
    fin      = 1'b0;
    case (state)
      ST_HEAD: begin
        feed_h = (idx >= 6'd12) && (idx <= 6'd28);
        feed_i = (idx >= 6'd37);
        done   = (idx == 6'd42);
        case (idx)
          6'd0:  byte_sel = 8'h89;
          6'd1:  byte_sel = 8'h50;
          6'd2:  byte_sel = 8'h4E;
          6'd3:  byte_sel = 8'h47;
          6'd4:  byte_sel = 8'h0D;
          6'd5:  byte_sel = 8'h0A;
          6'd6:  byte_sel = 8'h1A;
          6'd7:  byte_sel = 8'h0A;
          6'd11: byte_sel = 8'd13;
          6'd12: byte_sel = 8'h49;
          6'd13: byte_sel = 8'h48;
          6'd14: byte_sel = 8'h44;
          6'd15: byte_sel = 8'h52;
          6'd18: byte_sel = {3'd0, cur.width[12:8]};
          6'd19: byte_sel = cur.width[7:0];
          6'd22: byte_sel = {3'd0, cur.height[12:8]};
          6'd23: byte_sel = cur.height[7:0];
          6'd24: byte_sel = 8'd8;
          6'd25: byte_sel = 8'd6;
          6'd29: byte_sel = ~hcrc[31:24];
          6'd30: byte_sel = ~hcrc[23:16];
          6'd31: byte_sel = ~hcrc[15:8];
          6'd32: byte_sel = ~hcrc[7:0];
          6'd33: byte_sel = idat_len[31:24];
          6'd34: byte_sel = idat_len[23:16];
          6'd35: byte_sel = idat_len[15:8];
          6'd36: byte_sel = idat_len[7:0];
          6'd37: byte_sel = 8'h49;
          6'd38: byte_sel = 8'h44;
          6'd39: byte_sel = 8'h41;
          6'd40: byte_sel = 8'h54;
          6'd41: byte_sel = 8'h78;
          6'd42: byte_sel = 8'h01;
          default: byte_sel = 8'h00;
        endcase
      end
      ST_RAW: begin
        feed_i = 1'b1;
        if (block_left == '0) begin
          case (hidx)
            3'd0:    byte_sel = {7'd0, (raw_left <= RAW_W'(STORED_BLOCK_BYTES))};
            3'd1:    byte_sel = blk_len[7:0];
            3'd2:    byte_sel = blk_len[15:8];
            3'd3:    byte_sel = blk_nlen[7:0];
            default: byte_sel = blk_nlen[15:8];
          endcase
        end else begin
          is_raw   = 1'b1;
          byte_sel = raw_byte;
          done     = (raw_idx == 3'd4) && !cur.last_pix;
          to_tail  = (raw_idx == 3'd4) && cur.last_pix;
        end
      end
      ST_TAIL: begin
        feed_i = (idx <= 6'd3);
        done   = (idx == 6'd19);
        fin    = done;
        case (idx)
          6'd0:  byte_sel = adler_high[15:8];
          6'd1:  byte_sel = adler_high[7:0];
          6'd2:  byte_sel = adler_low[15:8];
          6'd3:  byte_sel = adler_low[7:0];
          6'd4:  byte_sel = ~idat_crc[31:24];
          6'd5:  byte_sel = ~idat_crc[23:16];
          6'd6:  byte_sel = ~idat_crc[15:8];
          6'd7:  byte_sel = ~idat_crc[7:0];
          6'd12: byte_sel = 8'h49;
          6'd13: byte_sel = 8'h45;
          6'd14: byte_sel = 8'h4E;
          6'd15: byte_sel = 8'h44;
          6'd16: byte_sel = 8'hAE;
          6'd17: byte_sel = 8'h42;
          6'd18: byte_sel = 8'h60;
          6'd19: byte_sel = 8'h82;
          default: byte_sel = 8'h00;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    if (q_take) begin
      state_next = (q_cmd.kind == CMD_START) ? ST_HEAD : ST_RAW;
    end else if (fire && done) begin
      state_next = ST_IDLE;
    end else if (fire && to_tail) begin
      state_next = ST_TAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idat_crc   <= CRC_INIT;
      adler_low  <= 16'd1;
      adler_high <= '0;
      block_left <= '0;
      raw_left   <= '0;
    end else begin
      if (fire) begin
        out_byte    <= byte_sel;
        last_of_run <= done;
        file_done   <= fin;
        if (feed_h) begin
          hcrc <= crc_byte(hcrc, byte_sel);
        end
        if (feed_i) begin
          idat_crc <= crc_byte(idat_crc, byte_sel);
        end
        case (state)
          ST_HEAD, ST_TAIL: idx <= idx + 6'd1;
          ST_RAW: begin
            if (is_raw) begin
              raw_idx    <= raw_idx + 3'd1;
              block_left <= block_left - 16'd1;
              raw_left   <= raw_left - RAW_W'(1);
              adler_low  <= low_mod[15:0];
              adler_high <= high_mod[15:0];
              idx        <= '0;
            end else if (hidx == 3'd4) begin
              hidx       <= '0;
              block_left <= blk_len;
            end else begin
              hidx <= hidx + 3'd1;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_HEAD) begin
        blocks   <= blk_q[10:0];
        idat_len <= 32'd6 + {5'd0, raw_left} + {19'd0, blocks, 2'b00} + {21'd0, blocks};
      end
      if (q_take) begin
        cur     <= q_cmd;
        idx     <= '0;
        hidx    <= '0;
        raw_idx <= q_cmd.first_col ? 3'd0 : 3'd1;
        if (q_cmd.kind == CMD_START) begin
          hcrc       <= CRC_INIT;
          idat_crc   <= CRC_INIT;
          adler_low  <= 16'd1;
          adler_high <= '0;
          block_left <= '0;
          raw_left   <= raw_full[RAW_W-1:0];
        end
      end
    end
  end

endmodule

// ===== hw/rtl/argb_to_png_stream_encoder.sv =====
// Channel   | signals                                  | direction
// ----------+------------------------------------------+----------
// input     | in_valid, in_ready, action, pixel_argb   | in
// output    | out_valid, out_ready, out_byte, last_of_run, file_done | out
// config    | cfg_write_en, cfg_index, cfg_data        | in
//
// One output word per cycle from the back end's output register while
// out_ready is high. A start item gives 43 bytes; a pixel gives 4 (5 at a
// row start), plus 5 for each stored-block header it crosses, plus 20 for
// the trailer after the last pixel. The front end accepts while the
// command queue has room, so it keeps taking items while the back end
// stalls on out_ready. Reset is synchronous; no clearing pass is needed.
// Top level of the PNG stream encoder; uses pngenc_pkg, pngenc_front,
// pngenc_cmdq and pngenc_back.
module argb_to_png_stream_encoder import pngenc_pkg::*; #(
  parameter int QUEUE_DEPTH = CMDQ_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             action,
  input  logic [31:0]      pixel_argb,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             file_done
);

  logic push;
  cmd_t push_cmd;
  logic q_wr_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_take;

  pngenc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .action       (action),
    .pixel_argb   (pixel_argb),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_ready      (q_wr_ready)
  );

  pngenc_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_cmd   (push_cmd),
    .wr_ready (q_wr_ready),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd),
    .rd_en    (q_take)
  );

  pngenc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_take      (q_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .file_done   (file_done)
  );

endmodule
